@@ hdl/qcws_pkg.sv @@
package qcws_pkg;

   typedef enum logic [1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_BUTTON = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic {
      CSR_BLINK_ON  = 1'b0,
      CSR_BLINK_OFF = 1'b1
   } csr_index_type;

   localparam int unsigned POS_W   = 9;
   localparam int unsigned DUTY_W  = 7;
   localparam int unsigned TICK_W  = 10;

   localparam logic [POS_W-1:0]  WHEEL_LAST   = 9'd299;
   localparam logic [POS_W-1:0]  SEG1_START   = 9'd100;
   localparam logic [POS_W-1:0]  SEG2_START   = 9'd200;
   localparam logic [DUTY_W-1:0] SEGMENT_SIZE = 7'd100;

   localparam logic [TICK_W-1:0] BLINK_ON_RESET  = 10'd400;
   localparam logic [TICK_W-1:0] BLINK_OFF_RESET = 10'd200;

   // previous pins : current pins, each as {A, B}
   localparam logic [3:0] ENC_UP_0   = 4'b1101;
   localparam logic [3:0] ENC_UP_1   = 4'b0100;
   localparam logic [3:0] ENC_UP_2   = 4'b0010;
   localparam logic [3:0] ENC_UP_3   = 4'b1011;
   localparam logic [3:0] ENC_DOWN_0 = 4'b1110;
   localparam logic [3:0] ENC_DOWN_1 = 4'b0111;
   localparam logic [3:0] ENC_DOWN_2 = 4'b0001;
   localparam logic [3:0] ENC_DOWN_3 = 4'b1000;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [1:0]        prev_pins;
      logic              adjust;
      logic              lit;
      logic [TICK_W-1:0] phase;
   } wheel_state_type;

   typedef struct packed {
      logic [DUTY_W-1:0] red;
      logic [DUTY_W-1:0] green;
      logic [DUTY_W-1:0] blue;
   } duty_type;

endpackage

@@ hdl/qcws_if.sv @@
interface qcws_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       pin_a;
   logic       pin_b;

   modport source (output valid, output action, output pin_a, output pin_b, input ready);
   modport sink   (input valid, input action, input pin_a, input pin_b, output ready);
endinterface

interface qcws_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] red_duty;
   logic [6:0] green_duty;
   logic [6:0] blue_duty;
   logic [8:0] wheel_position;
   logic       adjusting;

   modport source (output valid, output red_duty, output green_duty, output blue_duty,
                   output wheel_position, output adjusting, input ready);
   modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                   input wheel_position, input adjusting, output ready);
endinterface

@@ hdl/quadrature_color_wheel_selector.sv @@
// Channel   Dir  Payload
// req_ch    in   action, pin_a, pin_b
// rsp_ch    out  red_duty, green_duty, blue_duty, wheel_position, adjusting
// csr_*     in   csr_wr_en, csr_index, csr_wdata (blink on / off ticks)
//
// One item per cycle sustained while rsp_ch is ready; each item yields one result,
// passing through the input register and then the result register.
// The state update and colour mapping sit between those two registers.
// Reset clears the control state, except that the blink starts lit, and loads the blink registers with 400 and 200.
// A stalled result holds in its register; the input register still advances
// into it as soon as the result is taken, so no bubble follows a stall.
module quadrature_color_wheel_selector (
   input  logic       clock,
   input  logic       reset,
   qcws_req_if.sink   req_ch,
   qcws_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [9:0] csr_wdata
);
   import qcws_pkg::*;

   logic              in_valid_ff;
   action_type        in_action_ff;
   logic [1:0]        in_pins_ff;
   logic              rsp_valid_ff;
   duty_type          rsp_duty_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_adjust_ff;
   logic              out_free;
   logic              advance;
   logic              take;
   wheel_state_type   state_now;
   wheel_state_type   state_next;
   duty_type          duty_in;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign take         = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_action_ff <= action_type'(req_ch.action);
         in_pins_ff   <= {req_ch.pin_a, req_ch.pin_b};
      end
   end

   qcws_state u_state (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .action     (in_action_ff),
      .pins       (in_pins_ff),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .state_now  (state_now),
      .state_next (state_next)
   );

   qcws_colour u_colour (
      .state (state_next),
      .duty  (duty_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   // hold the result while the sink stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_duty_ff   <= duty_in;
         rsp_pos_ff    <= state_next.position;
         rsp_adjust_ff <= state_next.adjust;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.red_duty       = rsp_duty_ff.red;
   assign rsp_ch.green_duty     = rsp_duty_ff.green;
   assign rsp_ch.blue_duty      = rsp_duty_ff.blue;
   assign rsp_ch.wheel_position = rsp_pos_ff;
   assign rsp_ch.adjusting      = rsp_adjust_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pos_ff <= WHEEL_LAST))
      else $error("wheel position out of range");

   a_duty_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (({1'b0, rsp_duty_ff.red} + {1'b0, rsp_duty_ff.green}
                         + {1'b0, rsp_duty_ff.blue}) == {1'b0, SEGMENT_SIZE}
                        || rsp_duty_ff == '0))
      else $error("duties do not sum to a full segment");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |-> !req_ch.ready)
      else $error("input register overrun");

   a_idle_position: assert property (@(posedge clock) disable iff (reset)
      !state_now.adjust |=> $stable(state_now.position))
      else $error("position moved outside adjust mode");

endmodule

@@ hdl/qcws_state.sv @@
module qcws_state (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  qcws_pkg::action_type      action,
   input  logic [1:0]                pins,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [9:0]                csr_wdata,
   output qcws_pkg::wheel_state_type state_now,
   output qcws_pkg::wheel_state_type state_next
);
   import qcws_pkg::*;

   wheel_state_type   state_ff;
   wheel_state_type   state_in;
   logic [TICK_W-1:0] blink_on_ff;
   logic [TICK_W-1:0] blink_off_ff;
   logic [3:0]        enc_code;
   logic [TICK_W-1:0] limit;

   assign enc_code = {state_ff.prev_pins, pins};
   assign limit    = state_ff.lit ? blink_on_ff : blink_off_ff;

   always_comb begin
      state_in = state_ff;
      case (action)
         ACT_SAMPLE: begin
            if (state_ff.adjust) begin
               unique case (enc_code) inside
                  ENC_UP_0, ENC_UP_1, ENC_UP_2, ENC_UP_3: begin
                     state_in.position = (state_ff.position == WHEEL_LAST) ?
                                         '0 : state_ff.position + 1'b1;
                  end
                  ENC_DOWN_0, ENC_DOWN_1, ENC_DOWN_2, ENC_DOWN_3: begin
                     state_in.position = (state_ff.position == '0) ?
                                         WHEEL_LAST : state_ff.position - 1'b1;
                  end
                  default: begin
                     state_in.position = state_ff.position;
                  end
               endcase
               state_in.prev_pins = pins;
            end
         end
         ACT_BUTTON: begin
            state_in.adjust = !state_ff.adjust;
            // entering adjust mode restarts the blink lit
            if (!state_ff.adjust) begin
               state_in.lit   = 1'b1;
               state_in.phase = '0;
            end
         end
         ACT_TICK: begin
            if (state_ff.adjust) begin
               if (state_ff.phase >= limit) begin
                  state_in.lit   = !state_ff.lit;
                  state_in.phase = '0;
               end else begin
                  state_in.phase = state_ff.phase + 1'b1;
               end
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.position  <= '0;
         state_ff.prev_pins <= '0;
         state_ff.adjust    <= 1'b0;
         state_ff.lit       <= 1'b1;
         state_ff.phase     <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_on_ff  <= BLINK_ON_RESET;
         blink_off_ff <= BLINK_OFF_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_BLINK_ON) begin
            blink_on_ff <= csr_wdata;
         end else begin
            blink_off_ff <= csr_wdata;
         end
      end
   end

   assign state_now  = state_ff;
   assign state_next = state_in;

endmodule

@@ hdl/qcws_colour.sv @@
module qcws_colour (
   input  qcws_pkg::wheel_state_type state,
   output qcws_pkg::duty_type        duty
);
   import qcws_pkg::*;

   logic [POS_W-1:0]  offset;
   logic [DUTY_W-1:0] up;
   logic [DUTY_W-1:0] down;
   logic [1:0]        seg;
   logic              blank;

   always_comb begin
      if (state.position >= SEG2_START) begin
         seg    = 2'd2;
         offset = state.position - SEG2_START;
      end else if (state.position >= SEG1_START) begin
         seg    = 2'd1;
         offset = state.position - SEG1_START;
      end else begin
         seg    = 2'd0;
         offset = state.position;
      end
   end

   assign up    = offset[DUTY_W-1:0];
   assign down  = SEGMENT_SIZE - up;
   assign blank = state.adjust && !state.lit;

   always_comb begin
      duty = '0;
      if (!blank) begin
         case (seg)
            2'd0: begin
               duty.red   = down;
               duty.green = up;
            end
            2'd1: begin
               duty.green = down;
               duty.blue  = up;
            end
            default: begin
               duty.blue = down;
               duty.red  = up;
            end
         endcase
      end
   end

endmodule

@@ bench/wheel_checker.sv @@
`timescale 1ns / 1ps

module wheel_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_action,
   input  logic                        req_pin_a,
   input  logic                        req_pin_b,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [qcws_pkg::DUTY_W-1:0] rsp_red_duty,
   input  logic [qcws_pkg::DUTY_W-1:0] rsp_green_duty,
   input  logic [qcws_pkg::DUTY_W-1:0] rsp_blue_duty,
   input  logic [qcws_pkg::POS_W-1:0]  rsp_wheel_position,
   input  logic                        rsp_adjusting,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [qcws_pkg::TICK_W-1:0] csr_wdata,
   output int unsigned                 failures,
   output int unsigned                 outstanding
);
   import qcws_pkg::*;

   typedef struct packed {
      logic [DUTY_W-1:0] red;
      logic [DUTY_W-1:0] green;
      logic [DUTY_W-1:0] blue;
      logic [POS_W-1:0]  position;
      logic              adjusting;
   } wheel_result_type;

   wheel_state_type   wheel;
   logic [TICK_W-1:0] blink_on;
   logic [TICK_W-1:0] blink_off;
   wheel_result_type  expected_colours[$];
   int unsigned       mismatch_count = 0;

   // Apply one item to the local copy of the wheel state and return the colour it shows.
   function automatic wheel_result_type advance_wheel(input action_type act, input logic a,
                                                      input logic b);
      wheel_result_type  res;
      logic [TICK_W-1:0] limit;
      logic [POS_W-1:0]  ramp;
      res = '0;
      case (act)
         ACT_SAMPLE: begin
            if (wheel.adjust) begin
               case ({wheel.prev_pins, a, b}) inside
                  ENC_UP_0, ENC_UP_1, ENC_UP_2, ENC_UP_3:
                     wheel.position = (wheel.position == WHEEL_LAST) ? '0 : wheel.position + 1'b1;
                  ENC_DOWN_0, ENC_DOWN_1, ENC_DOWN_2, ENC_DOWN_3:
                     wheel.position = (wheel.position == '0) ? WHEEL_LAST : wheel.position - 1'b1;
                  default: ;
               endcase
               wheel.prev_pins = {a, b};
            end
         end
         ACT_BUTTON: begin
            wheel.adjust = ~wheel.adjust;
            if (wheel.adjust) begin
               wheel.lit   = 1'b1;
               wheel.phase = '0;
            end
         end
         ACT_TICK: begin
            if (wheel.adjust) begin
               limit = wheel.lit ? blink_on : blink_off;
               if (wheel.phase >= limit) begin
                  wheel.lit   = ~wheel.lit;
                  wheel.phase = '0;
               end else begin
                  wheel.phase = wheel.phase + 1'b1;
               end
            end
         end
         default: ;
      endcase

      res.position  = wheel.position;
      res.adjusting = wheel.adjust;
      // all channels stay dark in the off half of the blink
      if (!wheel.adjust || wheel.lit) begin
         if (wheel.position < SEG1_START) begin
            ramp      = wheel.position;
            res.red   = SEGMENT_SIZE - ramp[DUTY_W-1:0];
            res.green = ramp[DUTY_W-1:0];
         end else if (wheel.position < SEG2_START) begin
            ramp      = wheel.position - SEG1_START;
            res.green = SEGMENT_SIZE - ramp[DUTY_W-1:0];
            res.blue  = ramp[DUTY_W-1:0];
         end else begin
            ramp      = wheel.position - SEG2_START;
            res.blue  = SEGMENT_SIZE - ramp[DUTY_W-1:0];
            res.red   = ramp[DUTY_W-1:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      wheel_result_type got;
      wheel_result_type want;
      if (reset) begin
         wheel           = '0;
         wheel.lit       = 1'b1;
         blink_on        = BLINK_ON_RESET;
         blink_off       = BLINK_OFF_RESET;
         expected_colours.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_BLINK_ON:  blink_on  = csr_wdata;
               CSR_BLINK_OFF: blink_off = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_colours.push_back(advance_wheel(action_type'(req_action), req_pin_a,
                                                     req_pin_b));
         if (rsp_valid && rsp_ready) begin
            got = '{red: rsp_red_duty, green: rsp_green_duty, blue: rsp_blue_duty,
                    position: rsp_wheel_position, adjusting: rsp_adjusting};
            if (expected_colours.size() == 0) begin
               if (mismatch_count < 10) begin
                  $write("%0t: result with nothing expected:", $realtime);
                  $display(" r %0d g %0d b %0d pos %0d adj %0d",
                           got.red, got.green, got.blue, got.position, got.adjusting);
               end
               mismatch_count++;
            end else begin
               want = expected_colours.pop_front();
               if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
                   || got.position !== want.position || got.adjusting !== want.adjusting) begin
                  if (mismatch_count < 10) begin
                     $write("%0t: mismatch: expected r %0d g %0d b %0d pos %0d adj %0d,",
                            $realtime, want.red, want.green, want.blue, want.position,
                            want.adjusting);
                     $display(" got r %0d g %0d b %0d pos %0d adj %0d",
                              got.red, got.green, got.blue, got.position, got.adjusting);
                  end
                  mismatch_count++;
               end
            end
         end
      end
      failures    <= mismatch_count;
      outstanding <= expected_colours.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import qcws_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 4000;
   localparam int unsigned PHASE_ITEMS  = 150;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic              csr_index;
   logic [TICK_W-1:0] csr_wdata;
   int unsigned       failures;
   int unsigned       outstanding;
   int unsigned       idle_cycles = 0;
   int unsigned       burst_left = 0;
   logic              adjust_guess = 1'b0;
   logic [1:0]        pins_guess = 2'b00;

   qcws_req_if req_ch ();
   qcws_rsp_if rsp_ch ();

   quadrature_color_wheel_selector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wheel_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_ready          (req_ch.ready),
      .req_action         (req_ch.action),
      .req_pin_a          (req_ch.pin_a),
      .req_pin_b          (req_ch.pin_b),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_red_duty       (rsp_ch.red_duty),
      .rsp_green_duty     (rsp_ch.green_duty),
      .rsp_blue_duty      (rsp_ch.blue_duty),
      .rsp_wheel_position (rsp_ch.wheel_position),
      .rsp_adjusting      (rsp_ch.adjusting),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .failures           (failures),
      .outstanding        (outstanding)
   );

   always #1 clock = ~clock;

   // Next pin level of a clean quadrature step, {A, B}.
   function automatic logic [1:0] quad_step(input logic [1:0] pins, input logic upward);
      case (pins)
         2'b00:   return upward ? 2'b10 : 2'b01;
         2'b10:   return upward ? 2'b11 : 2'b00;
         2'b11:   return upward ? 2'b01 : 2'b10;
         default: return upward ? 2'b00 : 2'b11;
      endcase
   endfunction

   task automatic send_item(input action_type act, input logic [1:0] pins);
      int unsigned gap;
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.pin_a  <= pins[1];
      req_ch.pin_b  <= pins[0];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (act == ACT_BUTTON) adjust_guess = ~adjust_guess;
      if (act == ACT_SAMPLE && adjust_guess) pins_guess = pins;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 10);
      end
   endtask

   task automatic send_random();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (!adjust_guess && $urandom_range(0, 9) < 3)
         send_item(ACT_BUTTON, 2'($urandom_range(0, 3)));
      else if (pick < 55)
         send_item(ACT_SAMPLE, quad_step(pins_guess, 1'($urandom_range(0, 1))));
      else if (pick < 62)
         send_item(ACT_SAMPLE, 2'($urandom_range(0, 3)));
      else if (pick < 88)
         send_item(ACT_TICK, 2'($urandom_range(0, 3)));
      else if (pick < 95)
         send_item(ACT_BUTTON, 2'($urandom_range(0, 3)));
      else
         send_item(ACT_NONE, 2'($urandom_range(0, 3)));
   endtask

   // Hold the sender until every result is back, then let the pipe settle.
   task automatic drain();
      if (req_ch.valid) req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_blink(input logic [TICK_W-1:0] on_ticks,
                            input logic [TICK_W-1:0] off_ticks);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BLINK_ON;
      csr_wdata <= on_ticks;
      @(posedge clock);
      csr_index <= CSR_BLINK_OFF;
      csr_wdata <= off_ticks;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: ready pattern changes its character every so often
   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned count;
      rsp_ch.ready <= 1'b0;
      mode  = 0;
      span  = 0;
      count = 0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(30, 200);
         end
         span--;
         count++;
         case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            2:       rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            default: rsp_ch.ready <= (count % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [TICK_W-1:0] on_cfg[6];
      logic [TICK_W-1:0] off_cfg[6];
      req_ch.valid  <= 1'b0;
      req_ch.action <= ACT_NONE;
      req_ch.pin_a  <= 1'b0;
      req_ch.pin_b  <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_BLINK_ON;
      csr_wdata     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // outside adjust mode: samples, ticks and the unused action change nothing
      send_item(ACT_SAMPLE, 2'b11);
      send_item(ACT_NONE, 2'b00);
      send_item(ACT_TICK, 2'b00);
      send_item(ACT_BUTTON, 2'b00);
      // full cycle downwards through zero, then back up through the wrap
      send_item(ACT_SAMPLE, 2'b01);
      send_item(ACT_SAMPLE, 2'b11);
      send_item(ACT_SAMPLE, 2'b10);
      send_item(ACT_SAMPLE, 2'b00);
      send_item(ACT_SAMPLE, 2'b10);
      send_item(ACT_SAMPLE, 2'b11);
      send_item(ACT_SAMPLE, 2'b01);
      send_item(ACT_SAMPLE, 2'b00);
      // illegal double step and repeated level hold the position
      send_item(ACT_SAMPLE, 2'b11);
      send_item(ACT_SAMPLE, 2'b11);
      send_item(ACT_NONE, 2'b11);
      send_item(ACT_BUTTON, 2'b00);
      send_item(ACT_SAMPLE, 2'b00);
      send_item(ACT_BUTTON, 2'b00);
      drain();

      // zero registers: every tick flips the blink, dark half blanks all channels
      set_blink('0, '0);
      send_item(ACT_TICK, 2'b00);
      send_item(ACT_SAMPLE, quad_step(pins_guess, 1'b0));
      send_item(ACT_TICK, 2'b00);
      send_item(ACT_TICK, 2'b00);
      send_item(ACT_BUTTON, 2'b00);
      send_item(ACT_BUTTON, 2'b00);
      send_item(ACT_TICK, 2'b00);

      on_cfg  = '{10'd0,    10'd1023, 10'd1, 10'd0,    10'd0, 10'd0};
      off_cfg = '{10'd0,    10'd1023, 10'd0, 10'd1023, 10'd0, 10'd0};
      for (int ph = 0; ph < 7; ph++) begin
         if (ph > 0) begin
            drain();
            if (ph >= 5) begin
               on_cfg[ph-1]  = 10'($urandom_range(0, 6));
               off_cfg[ph-1] = 10'($urandom_range(0, 6));
            end
            set_blink(on_cfg[ph-1], off_cfg[ph-1]);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      end

      drain();
      if (failures == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/qcws_pkg.sv
hdl/qcws_if.sv
hdl/qcws_state.sv
hdl/qcws_colour.sv
hdl/quadrature_color_wheel_selector.sv
bench/wheel_checker.sv
bench/tb.sv
